@@ rtl/fdrs_pkg.sv @@
`timescale 1ns / 1ps
package fdrs_pkg;

   typedef enum logic {
      CMD_DRAW = 1'b0,
      CMD_FLIP = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_BUS  = 1'b0,
      KIND_WAIT = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_NUM_MODULES = 1'b0,
      CSR_FLIP_TIME   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STEP_MOD_OFF,
      STEP_COLUMN,
      STEP_ROW,
      STEP_MOD_ON,
      STEP_WAIT,
      STEP_ROW_OFF
   } step_type;

   localparam logic [6:0] ADDR_NONE   = 7'h00;
   localparam logic [6:0] ADDR_MODULE = 7'h20;
   localparam logic [6:0] ADDR_COLUMN = 7'h21;
   localparam logic [6:0] ADDR_ROW    = 7'h22;

   localparam logic [7:0] MODULE_OFF = 8'h00;
   localparam logic [7:0] MODULE_ON  = 8'hff;
   localparam logic [7:0] ROW_OFF    = 8'h00;

   localparam logic [3:0]  NUM_MODULES_RESET = 4'd1;
   localparam logic [15:0] FLIP_TIME_RESET   = 16'd550;

   localparam int ADDR_GROUP = 7;
   localparam int ROW_BANK   = 14;

   typedef struct packed {
      logic       cmd;
      logic [7:0] x;
      logic [4:0] y;
      logic       dot_on;
   } req_type;

   typedef struct packed {
      logic [2:0] col_a;
      logic [1:0] col_b;
      logic [2:0] row_a;
      logic       row_b;
      logic       upper;
      logic       frame_end;
   } flip_info_type;

endpackage

@@ rtl/fdrs_req_if.sv @@
`timescale 1ns / 1ps
interface fdrs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] x;
   logic [4:0] y;
   logic       dot_on;

   modport source (output valid, output cmd, output x, output y, output dot_on, input ready);
   modport sink (input valid, input cmd, input x, input y, input dot_on, output ready);
endinterface

@@ rtl/fdrs_rsp_if.sv @@
`timescale 1ns / 1ps
interface fdrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [6:0]  bus_address;
   logic [7:0]  bus_data;
   logic [15:0] wait_time;
   logic        last;
   logic        frame_end;

   modport source (
      output valid, output kind, output bus_address, output bus_data,
      output wait_time, output last, output frame_end, input ready
   );
   modport sink (
      input valid, input kind, input bus_address, input bus_data,
      input wait_time, input last, input frame_end, output ready
   );
endinterface

@@ rtl/fdrs_ram.sv @@
`timescale 1ns / 1ps
module fdrs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/flipdot_refresh_sequencer_top.sv @@
`timescale 1ns / 1ps
// flip-dot refresh sequencer
// req_ch carries draw and flip requests, rsp_ch carries bus writes and waits,
// csr_we/csr_index/csr_data write num_modules (index 0) and flip_time_us (1)
// a draw request writes one dot of the frame store and gives no response
// a flip request reads the dot under the scan cursor and gives six responses:
// module off, column byte, row byte, module on, wait, row off (last set)
// a flip goes through the input register, the emitter and the output register;
// its later responses follow one per cycle while rsp_ch.ready is high
// throughput: draws one per cycle unless a flip waits in the input register;
// a flip enters the six-step emitter as the last step of the flip before it
// is emitted, and the emitter feeds the single response register
// reset: the frame store is cleared one dot per cycle, req_ch.ready stays low
// meanwhile; csr writes are taken at any time
// stall: a response waits in the output register, the emitter holds its step,
// draws still pass the input register, the next flip waits there and holds
// req_ch.ready low
module flipdot_refresh_sequencer_top
   import fdrs_pkg::*;
#(
   parameter int MAX_MODULES = 8,
   parameter int DOTS_WIDE   = 28,
   parameter int DOTS_HIGH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   fdrs_req_if.sink    req_ch,
   fdrs_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int MAX_WIDTH = MAX_MODULES * DOTS_WIDE;
   localparam int DEPTH     = MAX_WIDTH * DOTS_HIGH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(DOTS_HIGH);
   localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
   localparam int CM_W      = $clog2(DOTS_WIDE);

   // configuration
   logic [3:0]  num_modules_ff;
   logic [15:0] flip_time_ff;
   logic [3:0]  mod_count;
   logic [WIDTH_W-1:0] width;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_modules_ff <= NUM_MODULES_RESET;
         flip_time_ff   <= FLIP_TIME_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_MODULES: num_modules_ff <= csr_data[3:0];
            CSR_FLIP_TIME:   flip_time_ff   <= csr_data;
            default:         num_modules_ff <= num_modules_ff;
         endcase
      end
   end

   always_comb begin
      if (num_modules_ff == 4'd0) begin
         mod_count = 4'd1;
      end else if (num_modules_ff > 4'(MAX_MODULES)) begin
         mod_count = 4'(MAX_MODULES);
      end else begin
         mod_count = num_modules_ff;
      end
      width = WIDTH_W'(32'(mod_count) * DOTS_WIDE);
   end

   // clearing pass
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    s1_go, accept, flip_go, draw_go, draw_ok;
   logic    s2_free;

   assign s1_go   = s1_valid_ff && (s1_ff.cmd == CMD_DRAW || s2_free);
   assign flip_go = s1_go && s1_ff.cmd == CMD_FLIP;
   assign draw_go = s1_go && s1_ff.cmd == CMD_DRAW;
   assign req_ch.ready = !clearing_ff && (!s1_valid_ff || s1_go);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_ff <= {req_ch.cmd, req_ch.x, req_ch.y, req_ch.dot_on};
      end
   end

   // scan cursor with its module and address-group counters
   logic [COL_W-1:0] scan_col_ff, scan_col_in, cur_col;
   logic [ROW_W-1:0] scan_row_ff, scan_row_in, cur_row;
   logic [CM_W-1:0]  col_m_ff, col_m_in, cur_m;
   logic [2:0]       col_m7_ff, col_m7_in, cur_m7;
   logic [2:0]       col_a_ff, col_a_in, cur_a;
   logic [1:0]       col_b_ff, col_b_in, cur_b;
   logic [2:0]       row_r7_ff, row_r7_in, cur_r7;
   logic             row_b_ff, row_b_in, cur_rb;
   logic             restart, frame_wrap;
   logic [WIDTH_W:0] col_plus;
   flip_info_type    flip_info;

   assign restart = {1'b0, scan_col_ff} >= (COL_W + 1)'(width)
                 || {1'b0, scan_row_ff} >= (ROW_W + 1)'(DOTS_HIGH);

   always_comb begin
      cur_col = restart ? '0 : scan_col_ff;
      cur_row = restart ? '0 : scan_row_ff;
      cur_m   = restart ? '0 : col_m_ff;
      cur_m7  = restart ? '0 : col_m7_ff;
      cur_a   = restart ? '0 : col_a_ff;
      cur_b   = restart ? '0 : col_b_ff;
      cur_r7  = restart ? '0 : row_r7_ff;
      cur_rb  = restart ? 1'b0 : row_b_ff;
      col_plus   = (WIDTH_W + 1)'(cur_col) + 1'b1;
      frame_wrap = 1'b0;

      scan_col_in = cur_col;
      scan_row_in = cur_row;
      col_m_in    = cur_m;
      col_m7_in   = cur_m7;
      col_a_in    = cur_a;
      col_b_in    = cur_b;
      row_r7_in   = cur_r7;
      row_b_in    = cur_rb;

      if (cur_row != ROW_W'(DOTS_HIGH - 1)) begin
         scan_row_in = cur_row + 1'b1;
         if (cur_r7 == 3'(ADDR_GROUP - 1)) begin
            row_r7_in = 3'd0;
            row_b_in  = ~cur_rb;
         end else begin
            row_r7_in = cur_r7 + 3'd1;
         end
      end else begin
         scan_row_in = '0;
         row_r7_in   = 3'd0;
         row_b_in    = 1'b0;
         if (col_plus >= {1'b0, width}) begin
            frame_wrap  = 1'b1;
            scan_col_in = '0;
            col_m_in    = '0;
            col_m7_in   = 3'd0;
            col_a_in    = 3'd0;
            col_b_in    = 2'd0;
         end else begin
            scan_col_in = cur_col + 1'b1;
            col_a_in    = (cur_a == 3'(ADDR_GROUP - 1)) ? 3'd0 : cur_a + 3'd1;
            if (cur_m == CM_W'(DOTS_WIDE - 1)) begin
               col_m_in  = '0;
               col_m7_in = 3'd0;
               col_b_in  = 2'd0;
            end else begin
               col_m_in = cur_m + 1'b1;
               if (cur_m7 == 3'(ADDR_GROUP - 1)) begin
                  col_m7_in = 3'd0;
                  col_b_in  = cur_b + 2'd1;
               end else begin
                  col_m7_in = cur_m7 + 3'd1;
               end
            end
         end
      end

      flip_info.col_a     = cur_a + 3'd1;
      flip_info.col_b     = cur_b;
      flip_info.row_a     = cur_r7 + 3'd1;
      flip_info.row_b     = cur_rb;
      flip_info.upper     = 5'(cur_row) >= 5'(ROW_BANK);
      flip_info.frame_end = frame_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= '0;
         scan_row_ff <= '0;
         col_m_ff    <= '0;
         col_m7_ff   <= 3'd0;
         col_a_ff    <= 3'd0;
         col_b_ff    <= 2'd0;
         row_r7_ff   <= 3'd0;
         row_b_ff    <= 1'b0;
      end else if (flip_go) begin
         scan_col_ff <= scan_col_in;
         scan_row_ff <= scan_row_in;
         col_m_ff    <= col_m_in;
         col_m7_ff   <= col_m7_in;
         col_a_ff    <= col_a_in;
         col_b_ff    <= col_b_in;
         row_r7_ff   <= row_r7_in;
         row_b_ff    <= row_b_in;
      end
   end

   // frame store
   logic              ram_we, ram_re, ram_wdata, ram_rdata;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr, draw_addr;

   assign draw_ok   = 32'(s1_ff.x) < 32'(width) && 32'(s1_ff.y) < DOTS_HIGH;
   assign draw_addr = ADDR_W'(32'(s1_ff.x) * DOTS_HIGH + 32'(s1_ff.y));
   assign ram_we    = clearing_ff || (draw_go && draw_ok);
   assign ram_waddr = clearing_ff ? clr_cnt_ff : draw_addr;
   assign ram_wdata = clearing_ff ? 1'b0 : s1_ff.dot_on;
   assign ram_re    = flip_go;
   assign ram_raddr = ADDR_W'(32'(cur_col) * DOTS_HIGH + 32'(cur_row));

   fdrs_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // six-step emitter
   logic          s2_valid_ff, s2_valid_in;
   step_type      step_ff, step_in;
   flip_info_type info_ff;
   logic          out_load, s2_emit, s2_done;
   logic          rsp_valid_ff;

   assign out_load = !rsp_valid_ff || rsp_ch.ready;
   assign s2_emit  = s2_valid_ff && out_load;
   assign s2_done  = s2_emit && step_ff == STEP_ROW_OFF;
   assign s2_free  = !s2_valid_ff || s2_done;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (flip_go) begin
         s2_valid_in = 1'b1;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (flip_go) begin
         step_in = STEP_MOD_OFF;
      end else if (s2_emit) begin
         unique case (step_ff)
            STEP_MOD_OFF: step_in = STEP_COLUMN;
            STEP_COLUMN:  step_in = STEP_ROW;
            STEP_ROW:     step_in = STEP_MOD_ON;
            STEP_MOD_ON:  step_in = STEP_WAIT;
            STEP_WAIT:    step_in = STEP_ROW_OFF;
            STEP_ROW_OFF: step_in = STEP_MOD_OFF;
            default:      step_in = STEP_MOD_OFF;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         step_ff     <= STEP_MOD_OFF;
      end else begin
         s2_valid_ff <= s2_valid_in;
         step_ff     <= step_in;
      end
      if (flip_go) begin
         info_ff <= flip_info;
      end
   end

   // response fields for the current step
   kind_type    res_kind;
   logic [6:0]  res_address;
   logic [7:0]  res_data, col_byte, row_byte;
   logic [15:0] res_wait;
   logic        res_last;

   assign col_byte = {info_ff.row_a[2], ~ram_rdata, info_ff.col_a[0], info_ff.col_a[1],
                      info_ff.col_a[2], info_ff.col_b[0], info_ff.col_b[1], 1'b0};
   assign row_byte = {info_ff.upper, ram_rdata, ~info_ff.upper, ram_rdata, ~ram_rdata,
                      info_ff.row_b, info_ff.row_a[0], info_ff.row_a[1]};

   always_comb begin
      res_kind    = KIND_BUS;
      res_address = ADDR_NONE;
      res_data    = 8'd0;
      res_wait    = 16'd0;
      res_last    = 1'b0;
      unique case (step_ff)
         STEP_MOD_OFF: begin
            res_address = ADDR_MODULE;
            res_data    = MODULE_OFF;
         end
         STEP_COLUMN: begin
            res_address = ADDR_COLUMN;
            res_data    = col_byte;
         end
         STEP_ROW: begin
            res_address = ADDR_ROW;
            res_data    = row_byte;
         end
         STEP_MOD_ON: begin
            res_address = ADDR_MODULE;
            res_data    = MODULE_ON;
         end
         STEP_WAIT: begin
            res_kind = KIND_WAIT;
            res_wait = flip_time_ff;
         end
         STEP_ROW_OFF: begin
            res_address = ADDR_ROW;
            res_data    = ROW_OFF;
            res_last    = 1'b1;
         end
         default: begin
            res_kind = KIND_BUS;
         end
      endcase
   end

   // output register
   logic        rsp_kind_ff;
   logic [6:0]  rsp_address_ff;
   logic [7:0]  rsp_data_ff;
   logic [15:0] rsp_wait_ff;
   logic        rsp_last_ff;
   logic        rsp_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s2_emit) begin
         rsp_kind_ff    <= res_kind;
         rsp_address_ff <= res_address;
         rsp_data_ff    <= res_data;
         rsp_wait_ff    <= res_wait;
         rsp_last_ff    <= res_last;
         rsp_fend_ff    <= info_ff.frame_end;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_kind_ff;
   assign rsp_ch.bus_address = rsp_address_ff;
   assign rsp_ch.bus_data    = rsp_data_ff;
   assign rsp_ch.wait_time   = rsp_wait_ff;
   assign rsp_ch.last        = rsp_last_ff;
   assign rsp_ch.frame_end   = rsp_fend_ff;

`ifndef SYNTHESIS
   a_last_is_row_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_address_ff == ADDR_ROW && rsp_data_ff == ROW_OFF))
      else $error("last response is not a row disable");

   a_step_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_load && !flip_go) |=> $stable(step_ff))
      else $error("emitter step moved while output stalled");

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_re && ram_we))
      else $error("frame store read and write in the same cycle");

   a_cursor_in_frame: assert property (@(posedge clock) disable iff (reset)
      flip_go |=> ({1'b0, scan_row_ff} < (ROW_W + 1)'(DOTS_HIGH)))
      else $error("scan row left the frame");

   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("request in flight during clearing pass");
`endif

endmodule

@@ tb/flipdot_sequence_checker.sv @@
`timescale 1ns / 1ps
module flipdot_sequence_checker
   import fdrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   fdrs_req_if           req_mon,
   fdrs_rsp_if           rsp_mon,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_data,
   output int            mismatch_count,
   output int            ops_outstanding,
   output int            frame_ends_seen
);

   localparam int MODULES_MAX = 8;
   localparam int MODULE_COLS = 28;
   localparam int MODULE_ROWS = 16;
   localparam int DOT_COUNT   = MODULES_MAX * MODULE_COLS * MODULE_ROWS;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  bus_address;
      logic [7:0]  bus_data;
      logic [15:0] wait_time;
      logic        last;
      logic        frame_end;
   } bus_op_type;

   logic        dot_map [DOT_COUNT];
   int unsigned cursor_col;
   int unsigned cursor_row;
   logic [3:0]  modules_cfg;
   logic [15:0] flip_us_cfg;
   bus_op_type  expected_ops [$];
   int          errors = 0;
   int          frame_ends = 0;

   function automatic int unsigned frame_cols();
      int unsigned m;
      m = modules_cfg;
      if (m < 1) m = 1;
      if (m > MODULES_MAX) m = MODULES_MAX;
      return m * MODULE_COLS;
   endfunction

   function automatic string op_text(bus_op_type op);
      return $sformatf("kind=%0d addr=%h data=%h wait=%0d last=%b frame_end=%b",
                       op.kind, op.bus_address, op.bus_data, op.wait_time, op.last,
                       op.frame_end);
   endfunction

   task automatic push_op(kind_type k, logic [6:0] addr, logic [7:0] data,
                          logic [15:0] wait_us, logic last, logic fend);
      bus_op_type op;
      op.kind        = k;
      op.bus_address = addr;
      op.bus_data    = data;
      op.wait_time   = wait_us;
      op.last        = last;
      op.frame_end   = fend;
      expected_ops.push_back(op);
   endtask

   task automatic store_dot(int unsigned x, int unsigned y, logic lit);
      if (x < frame_cols() && y < MODULE_ROWS) begin
         dot_map[x * MODULE_ROWS + y] = lit;
      end
   endtask

   task automatic predict_flip();
      int unsigned cols, x, y, col_b, col_a, row_local, row_b, row_a;
      logic        lit, fend;
      logic [7:0]  col_byte, row_byte;
      cols = frame_cols();
      if (cursor_col >= cols || cursor_row >= MODULE_ROWS) begin
         cursor_col = 0;
         cursor_row = 0;
      end
      x = cursor_col;
      y = cursor_row;
      lit = dot_map[x * MODULE_ROWS + y];
      col_b = (x % MODULE_COLS) / ADDR_GROUP;
      col_a = (x % ADDR_GROUP) + 1;
      row_local = y % ROW_BANK;
      row_b = row_local / ADDR_GROUP;
      row_a = (row_local % ADDR_GROUP) + 1;
      col_byte = {row_a[2], ~lit, col_a[0], col_a[1], col_a[2], col_b[0], col_b[1], 1'b0};
      row_byte = {(y >= ROW_BANK), lit, (y < ROW_BANK), lit, ~lit,
                  row_b[0], row_a[0], row_a[1]};
      fend = 1'b0;
      cursor_row++;
      if (cursor_row >= MODULE_ROWS) begin
         cursor_row = 0;
         cursor_col++;
         if (cursor_col >= cols) begin
            cursor_col = 0;
            fend = 1'b1;
            frame_ends++;
         end
      end
      push_op(KIND_BUS, ADDR_MODULE, MODULE_OFF, '0, 1'b0, fend);
      push_op(KIND_BUS, ADDR_COLUMN, col_byte, '0, 1'b0, fend);
      push_op(KIND_BUS, ADDR_ROW, row_byte, '0, 1'b0, fend);
      push_op(KIND_BUS, ADDR_MODULE, MODULE_ON, '0, 1'b0, fend);
      push_op(KIND_WAIT, ADDR_NONE, '0, flip_us_cfg, 1'b0, fend);
      push_op(KIND_BUS, ADDR_ROW, ROW_OFF, '0, 1'b1, fend);
   endtask

   task automatic compare_op();
      bus_op_type want, got;
      got.kind        = kind_type'(rsp_mon.kind);
      got.bus_address = rsp_mon.bus_address;
      got.bus_data    = rsp_mon.bus_data;
      got.wait_time   = rsp_mon.wait_time;
      got.last        = rsp_mon.last;
      got.frame_end   = rsp_mon.frame_end;
      if (expected_ops.size() == 0) begin
         errors++;
         if (errors <= 100) begin
            $display("%0t unexpected bus op: expected none, actual %s", $time, op_text(got));
         end
      end else begin
         want = expected_ops.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 100) begin
               $display("%0t bus op mismatch: expected %s, actual %s",
                        $time, op_text(want), op_text(got));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (dot_map[i]) dot_map[i] = 1'b0;
         cursor_col = 0;
         cursor_row = 0;
         modules_cfg = NUM_MODULES_RESET;
         flip_us_cfg = FLIP_TIME_RESET;
         expected_ops.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) compare_op();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.cmd == CMD_FLIP) predict_flip();
            else store_dot(req_mon.x, req_mon.y, req_mon.dot_on);
         end
         if (csr_we) begin
            if (csr_index == CSR_NUM_MODULES) modules_cfg = csr_data[3:0];
            else flip_us_cfg = csr_data;
         end
      end
      mismatch_count  <= errors;
      ops_outstanding <= expected_ops.size();
      frame_ends_seen <= frame_ends;
   end

endmodule

@@ tb/tb_flipdot_refresh_sequencer_top.sv @@
`timescale 1ns / 1ps
module tb_flipdot_refresh_sequencer_top;
   import fdrs_pkg::*;

   localparam int MODULE_ROWS  = 16;
   localparam int DRAIN_CYCLES = 8;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we;
   csr_index_type csr_index;
   logic [15:0]   csr_data;
   int            tx_idle_pct = 15;
   int            rx_idle_pct = 50;
   int            draws_sent = 0;
   int            flips_sent = 0;
   int            mismatch_count;
   int            ops_outstanding;
   int            frame_ends_seen;

   fdrs_req_if req_if ();
   fdrs_rsp_if rsp_if ();

   flipdot_refresh_sequencer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   flipdot_sequence_checker flip_chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .ops_outstanding (ops_outstanding),
      .frame_ends_seen (frame_ends_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic send_request(cmd_type c, logic [7:0] px, logic [4:0] py, logic lit);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.cmd    <= c;
      req_if.x      <= px;
      req_if.y      <= py;
      req_if.dot_on <= lit;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      if (c == CMD_FLIP) flips_sent++;
      else draws_sent++;
   endtask

   task automatic configure(logic [15:0] modules_word, logic [15:0] flip_us);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_MODULES;
      csr_data  <= modules_word;
      @(posedge clock);
      csr_index <= CSR_FLIP_TIME;
      csr_data  <= flip_us;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (ops_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_stream(int flip_total, int draw_total, int cols);
      int         flips_left;
      int         draws_left;
      logic [7:0] px;
      logic [4:0] py;
      flips_left = flip_total;
      draws_left = draw_total;
      while (flips_left + draws_left > 0) begin
         if ($urandom_range(flips_left + draws_left - 1) < flips_left) begin
            send_request(CMD_FLIP, 8'($urandom), 5'($urandom), 1'($urandom));
            flips_left--;
         end else begin
            px = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(cols - 1));
            py = ($urandom_range(7) == 0) ? 5'($urandom)
                                          : 5'($urandom_range(MODULE_ROWS - 1));
            send_request(CMD_DRAW, px, py, 1'($urandom));
            draws_left--;
         end
      end
   endtask

   initial begin
      csr_we        = 1'b0;
      csr_index     = CSR_NUM_MODULES;
      csr_data      = '0;
      req_if.valid  = 1'b0;
      req_if.cmd    = CMD_DRAW;
      req_if.x      = '0;
      req_if.y      = '0;
      req_if.dot_on = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one module, zero flip time
      configure(16'd1, 16'd0);
      send_request(CMD_DRAW, 8'd0, 5'd0, 1'b1);
      send_request(CMD_DRAW, 8'd0, 5'd1, 1'b1);
      send_request(CMD_DRAW, 8'd0, 5'd2, 1'b1);
      send_request(CMD_DRAW, 8'd27, 5'd15, 1'b1);
      send_request(CMD_DRAW, 8'd28, 5'd0, 1'b1);
      send_request(CMD_DRAW, 8'd255, 5'd31, 1'b1);
      send_request(CMD_DRAW, 8'd0, 5'd16, 1'b1);
      send_request(CMD_DRAW, 8'd0, 5'd2, 1'b0);
      send_request(CMD_DRAW, 8'd13, 5'd14, 1'b1);
      send_request(CMD_DRAW, 8'd6, 5'd13, 1'b1);
      send_request(CMD_FLIP, 8'd0, 5'd0, 1'b0);
      send_request(CMD_FLIP, 8'd255, 5'd31, 1'b1);
      send_request(CMD_FLIP, 8'd0, 5'd0, 1'b0);
      send_request(CMD_FLIP, 8'd0, 5'd0, 1'b0);
      send_request(CMD_DRAW, 8'd0, 5'd4, 1'b1);
      send_request(CMD_FLIP, 8'd0, 5'd0, 1'b0);
      send_request(CMD_DRAW, 8'd0, 5'd0, 1'b0);
      send_request(CMD_FLIP, 8'd0, 5'd0, 1'b0);
      send_request(CMD_FLIP, 8'd0, 5'd0, 1'b0);
      settle();

      // module count zero acts as one
      configure(16'd0, 16'hffff);
      random_stream(20, 10, 28);
      settle();

      // two modules
      configure(16'd2, 16'($urandom_range(1, 65535)));
      random_stream(15, 10, 56);
      settle();

      // one module written with high bits set
      tx_idle_pct <= 50;
      rx_idle_pct <= 15;
      configure(16'hfff1, 16'd1);
      random_stream(10, 5, 28);
      settle();

      configure(16'd8, 16'($urandom_range(1, 65535)));
      random_stream(8, 7, 224);
      settle();

      // count above the maximum acts as the maximum
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      configure(16'd15, 16'($urandom_range(1, 65535)));
      random_stream(10, 5, 224);
      settle();

      $display("covered %0d draw and %0d flip requests over six csr settings", draws_sent,
               flips_sent);
      $display("including out-of-frame draws, zero flip time and clamped module counts, %0d %s",
               frame_ends_seen, "frame ends");
      if (mismatch_count == 0 && ops_outstanding == 0) begin
         $display("[flipdot_refresh_sequencer_top] OK");
      end else begin
         $display("[flipdot_refresh_sequencer_top] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[flipdot_refresh_sequencer_top] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/fdrs_pkg.sv
rtl/fdrs_req_if.sv
rtl/fdrs_rsp_if.sv
rtl/fdrs_ram.sv
rtl/flipdot_refresh_sequencer_top.sv
tb/flipdot_sequence_checker.sv
tb/tb_flipdot_refresh_sequencer_top.sv
